[hdl/gdsr_pkg.sv]
// ----------------------------------------------------------------------------
// gdsr_pkg
// shared types, constants and report encoding for the gamepad debounce block
// ----------------------------------------------------------------------------
package gdsr_pkg;

  localparam int TICK_COUNT_WIDTH = 8;
  localparam int WORD_W           = 17;
  localparam int CFG_W            = 8;
  localparam int BTN_W            = 15;
  localparam int HAT_W            = 4;
  localparam int TRIG_W           = 7;
  localparam int IN_TDATA_W       = 24;
  localparam int OUT_TDATA_W      = 40;
  localparam int PADDR_W          = 3;

  localparam logic [CFG_W-1:0]  DEBOUNCE_RESET = 8'd20;
  localparam logic [TRIG_W-1:0] TRIGGER_ON     = 7'd127;
  localparam logic [TRIG_W-1:0] TRIGGER_OFF    = 7'd0;

  // register index taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;

  // word bit positions
  localparam int W_UP    = 0;
  localparam int W_DOWN  = 1;
  localparam int W_LEFT  = 2;
  localparam int W_RIGHT = 3;
  localparam int W_LT    = 10;
  localparam int W_RT    = 11;

  localparam logic [HAT_W-1:0] HAT_CENTER     = 4'd0;
  localparam logic [HAT_W-1:0] HAT_UP         = 4'd1;
  localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd2;
  localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd3;
  localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd4;
  localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd5;
  localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd6;
  localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd7;
  localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd8;

  localparam int BTN_MAP_N = 13;
  localparam int BTN_SRC [BTN_MAP_N] = '{5, 6, 4, 7, 8, 9, 10, 11, 12, 13, 16, 14, 15};
  localparam int BTN_DST [BTN_MAP_N] = '{0, 1, 4, 3, 6, 7, 8, 9, 10, 11, 12, 13, 14};

  typedef struct packed {
    logic              refresh_request;
    logic              host_suspended;
    logic              host_ready;
    logic [WORD_W-1:0] pressed_bits;
  } item_t;

  typedef struct packed {
    logic [TRIG_W-1:0] right_trigger;
    logic [TRIG_W-1:0] left_trigger;
    logic [HAT_W-1:0]  hat_code;
    logic [BTN_W-1:0]  button_field;
    logic              wake_request;
    logic              report_valid;
  } result_t;

  typedef struct packed {
    logic [BTN_W-1:0]  button_field;
    logic [HAT_W-1:0]  hat_code;
    logic [TRIG_W-1:0] left_trigger;
    logic [TRIG_W-1:0] right_trigger;
  } report_t;

  // debounce side to report side
  typedef struct packed {
    logic [WORD_W-1:0] stable_word;
    logic              send_try;
    logic              wake_request;
  } send_t;

  function automatic logic [BTN_W-1:0] buttons_of(input logic [WORD_W-1:0] w);
    logic [BTN_W-1:0] b;
    b = '0;
    for (int i = 0; i < BTN_MAP_N; i++) begin
      b[BTN_DST[i]] = w[BTN_SRC[i]];
    end
    return b;
  endfunction

  function automatic logic [HAT_W-1:0] hat_of(input logic [WORD_W-1:0] w);
    logic up;
    logic down;
    logic left;
    logic right;
    logic [HAT_W-1:0] h;
    up    = w[W_UP] & ~w[W_DOWN];
    down  = w[W_DOWN] & ~w[W_UP];
    left  = w[W_LEFT] & ~w[W_RIGHT];
    right = w[W_RIGHT] & ~w[W_LEFT];
    if (up && right) h = HAT_UP_RIGHT;
    else if (right && down) h = HAT_DOWN_RIGHT;
    else if (down && left) h = HAT_DOWN_LEFT;
    else if (left && up) h = HAT_UP_LEFT;
    else if (up) h = HAT_UP;
    else if (right) h = HAT_RIGHT;
    else if (down) h = HAT_DOWN;
    else if (left) h = HAT_LEFT;
    else h = HAT_CENTER;
    return h;
  endfunction

endpackage

[hdl/gdsr_debounce.sv]
// ----------------------------------------------------------------------------
// gdsr_debounce
// raw word tracking, stable tick count, adoption and send pending mark
// ----------------------------------------------------------------------------
module gdsr_debounce (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  gdsr_pkg::item_t          item,
  input  logic [gdsr_pkg::CFG_W-1:0] debounce_ticks,
  output gdsr_pkg::send_t          send
);
  import gdsr_pkg::*;

  localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;
  localparam logic [TICK_COUNT_WIDTH-1:0] TICK_MAX = '1;

  logic [WORD_W-1:0]           raw_word;
  logic [WORD_W-1:0]           stable_word;
  logic [TICK_COUNT_WIDTH-1:0] stable_ticks;
  logic                        send_pending;

  logic [WORD_W-1:0]           stable_word_next;
  logic [TICK_COUNT_WIDTH-1:0] stable_ticks_next;
  logic                        send_pending_next;
  logic                        changed;
  logic                        adopt;
  logic                        pend_mid;

  always_comb begin
    changed = item.pressed_bits != raw_word;
    if (changed) stable_ticks_next = '0;
    else if (stable_ticks != TICK_MAX) stable_ticks_next = stable_ticks + 1'b1;
    else stable_ticks_next = stable_ticks;

    adopt = (CMP_W'(stable_ticks_next) >= CMP_W'(debounce_ticks)) &&
            (stable_word != item.pressed_bits);
    stable_word_next  = adopt ? item.pressed_bits : stable_word;
    pend_mid          = send_pending | item.refresh_request | adopt;
    send_pending_next = pend_mid & ~item.host_ready;

    send.stable_word  = stable_word_next;
    send.send_try     = pend_mid & item.host_ready;
    send.wake_request = adopt & item.host_suspended & (item.pressed_bits != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_word     <= '0;
      stable_word  <= '0;
      stable_ticks <= TICK_MAX;
      send_pending <= 1'b1;
    end else if (advance) begin
      raw_word     <= item.pressed_bits;
      stable_word  <= stable_word_next;
      stable_ticks <= stable_ticks_next;
      send_pending <= send_pending_next;
    end
  end

endmodule

[hdl/gdsr_report.sv]
// ----------------------------------------------------------------------------
// gdsr_report
// report encoding and suppression of unchanged reports
// ----------------------------------------------------------------------------
module gdsr_report (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  gdsr_pkg::send_t   send,
  output gdsr_pkg::result_t result
);
  import gdsr_pkg::*;

  report_t last_report;
  report_t rep;
  logic    fire;

  always_comb begin
    rep.button_field  = buttons_of(send.stable_word);
    rep.hat_code      = hat_of(send.stable_word);
    rep.left_trigger  = send.stable_word[W_LT] ? TRIGGER_ON : TRIGGER_OFF;
    rep.right_trigger = send.stable_word[W_RT] ? TRIGGER_ON : TRIGGER_OFF;
    fire = send.send_try && (rep != last_report);

    result.report_valid  = fire;
    result.wake_request  = send.wake_request;
    result.button_field  = fire ? rep.button_field : '0;
    result.hat_code      = fire ? rep.hat_code : HAT_CENTER;
    result.left_trigger  = fire ? rep.left_trigger : TRIGGER_OFF;
    result.right_trigger = fire ? rep.right_trigger : TRIGGER_OFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_report <= '0;
    end else if (advance && fire) begin
      last_report <= rep;
    end
  end

endmodule

[hdl/gdsr_out_queue.sv]
// ----------------------------------------------------------------------------
// gdsr_out_queue
// two-entry result buffer between the processing stage and the output
// ----------------------------------------------------------------------------
module gdsr_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gdsr_pkg::result_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output gdsr_pkg::result_t out_data,
  output logic [1:0]        count
);
  import gdsr_pkg::*;

  result_t entry0;
  result_t entry1;
  logic    pop;

  assign pop       = out_valid & out_ready;
  assign room      = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) entry0 <= push_data;
        else entry1 <= push_data;
      end
      2'b01: begin
        entry0 <= entry1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          entry0 <= push_data;
        end else begin
          entry0 <= entry1;
          entry1 <= push_data;
        end
      end
      default: begin
        entry0 <= entry0;
      end
    endcase
  end

endmodule

[hdl/gamepad_debounce_socd_report_top.sv]
// an accepted request is held in the input register; its result is pushed into
// the result buffer and driven on m_tdata from there
// throughput: one request per cycle while results are taken; a two-entry
// result buffer parts the output from the input register
// reset: debounce_ticks = 20, stable count saturated, send pending, last report 0
// ----------------------------------------------------------------------------
// gamepad_debounce_socd_report_top
// gamepad button debounce with opposing-direction hat resolution and report
// ----------------------------------------------------------------------------
module gamepad_debounce_socd_report_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pressed_bits[16:0], host_ready[17], host_suspended[18], refresh_request[19]
  input  logic [gdsr_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // report_valid[0], wake_request[1], button_field[16:2], hat_code[20:17],
  // left_trigger[27:21], right_trigger[34:28]
  output logic [gdsr_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gdsr_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import gdsr_pkg::*;

  logic             [CFG_W-1:0] debounce_ticks;
  item_t            stage;
  logic             stage_valid;
  logic             advance;
  logic             room;
  logic [1:0]       out_count;
  send_t            send;
  result_t          result;
  result_t          out_data;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DEBOUNCE)) begin
      debounce_ticks <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEBOUNCE) ? {{(32-CFG_W){1'b0}}, debounce_ticks} : 32'd0;

  assign advance  = stage_valid & room;
  assign s_tready = ~stage_valid | room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage <= s_tdata[$bits(item_t)-1:0];
    end
  end

  gdsr_debounce u_debounce (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .item           (stage),
    .debounce_ticks (debounce_ticks),
    .send           (send)
  );

  gdsr_report u_report (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .send    (send),
    .result  (result)
  );

  gdsr_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (result),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_data),
    .count     (out_count)
  );

  assign m_tdata = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, out_data};

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_count != 2'd3) else $error("result buffer count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    out_count == 2'd2 |-> !advance) else $error("push into full result buffer");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_tready) else $error("input not ready after reset");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[34:2] == 33'd0)
    else $error("report fields set without a report");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// streams poll ticks through the gamepad debounce block, predicts each report
// in lockstep and compares every result field, across several debounce settings
// ----------------------------------------------------------------------------
module tb;
  import gdsr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [PADDR_W-1:0] ADDR_DEBOUNCE = {REG_DEBOUNCE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNUSED   = {~REG_DEBOUNCE, 2'b00};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  gamepad_debounce_socd_report_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted block state
  logic [CFG_W-1:0]            debounce_cfg;
  logic [WORD_W-1:0]           cur_raw;
  logic [WORD_W-1:0]           cur_stable;
  logic [TICK_COUNT_WIDTH-1:0] stable_cnt;
  logic                        send_due;
  report_t                     sent_report;

  item_t   poll_queue[$];
  result_t expected_reports[$];

  int  fail_count = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  logic in_taken = 1'b0;

  int  send_gap = 0;
  int  send_calm = 0;
  int  send_roll;
  int  recv_hold = 0;
  int  recv_calm = 0;
  int  recv_roll;
  int  next_hold_at = 40;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t report_for_poll(input item_t it);
    result_t r;
    report_t rep;
    logic    u;
    logic    d;
    logic    lf;
    logic    rg;
    r = '0;
    if (it.refresh_request) send_due = 1'b1;
    if (it.pressed_bits != cur_raw) begin
      cur_raw = it.pressed_bits;
      stable_cnt = '0;
    end else if (stable_cnt != '1) begin
      stable_cnt = stable_cnt + 1'b1;
    end
    if (stable_cnt >= debounce_cfg && cur_stable != cur_raw) begin
      cur_stable = cur_raw;
      send_due = 1'b1;
      r.wake_request = it.host_suspended && (cur_stable != '0);
    end
    if (send_due && it.host_ready) begin
      rep = '0;
      rep.button_field[0]  = cur_stable[5];
      rep.button_field[1]  = cur_stable[6];
      rep.button_field[3]  = cur_stable[7];
      rep.button_field[4]  = cur_stable[4];
      rep.button_field[6]  = cur_stable[8];
      rep.button_field[7]  = cur_stable[9];
      rep.button_field[8]  = cur_stable[10];
      rep.button_field[9]  = cur_stable[11];
      rep.button_field[10] = cur_stable[12];
      rep.button_field[11] = cur_stable[13];
      rep.button_field[12] = cur_stable[16];
      rep.button_field[13] = cur_stable[14];
      rep.button_field[14] = cur_stable[15];
      // opposing directions cancel
      u  = cur_stable[W_UP] & ~cur_stable[W_DOWN];
      d  = cur_stable[W_DOWN] & ~cur_stable[W_UP];
      lf = cur_stable[W_LEFT] & ~cur_stable[W_RIGHT];
      rg = cur_stable[W_RIGHT] & ~cur_stable[W_LEFT];
      case ({u, d, lf, rg})
        4'b1000: rep.hat_code = HAT_UP;
        4'b1001: rep.hat_code = HAT_UP_RIGHT;
        4'b0001: rep.hat_code = HAT_RIGHT;
        4'b0101: rep.hat_code = HAT_DOWN_RIGHT;
        4'b0100: rep.hat_code = HAT_DOWN;
        4'b0110: rep.hat_code = HAT_DOWN_LEFT;
        4'b0010: rep.hat_code = HAT_LEFT;
        4'b1010: rep.hat_code = HAT_UP_LEFT;
        default: rep.hat_code = HAT_CENTER;
      endcase
      rep.left_trigger  = cur_stable[W_LT] ? TRIGGER_ON : TRIGGER_OFF;
      rep.right_trigger = cur_stable[W_RT] ? TRIGGER_ON : TRIGGER_OFF;
      if (rep != sent_report) begin
        sent_report = rep;
        r.report_valid  = 1'b1;
        r.button_field  = rep.button_field;
        r.hat_code      = rep.hat_code;
        r.left_trigger  = rep.left_trigger;
        r.right_trigger = rep.right_trigger;
      end
      send_due = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    case ($urandom_range(0, 5))
      3: w = WORD_W'($urandom_range(0, 15));
      4: w = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      5: w = '0;
      default: w = WORD_W'($urandom);
    endcase
    return w;
  endfunction

  task automatic queue_poll(input logic [WORD_W-1:0] w, input logic ready,
                            input logic susp, input logic refresh);
    item_t it;
    it.pressed_bits    = w;
    it.host_ready      = ready;
    it.host_suspended  = susp;
    it.refresh_request = refresh;
    poll_queue.push_back(it);
  endtask

  task automatic queue_poll_rand(input logic [WORD_W-1:0] w);
    queue_poll(w, $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0,
               $urandom_range(0, 9) == 0);
  endtask

  // mostly held words long enough to pass the debounce, plus chatter and noise
  task automatic poll_sequences(input int n_seq);
    logic [WORD_W-1:0] w;
    int                len;
    for (int s = 0; s < n_seq; s++) begin
      w = rand_word();
      case ($urandom_range(0, 9))
        0: len = 1;
        1, 2: begin
          repeat ($urandom_range(1, 4))
            queue_poll_rand(w ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1)));
          len = int'(debounce_cfg) + $urandom_range(1, 4);
        end
        3: len = (debounce_cfg == 0) ? 1 : $urandom_range(1, int'(debounce_cfg));
        default: len = int'(debounce_cfg) + $urandom_range(1, 4);
      endcase
      repeat (len) queue_poll_rand(w);
    end
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_DEBOUNCE) debounce_cfg = data[CFG_W-1:0];
  endtask

  task automatic wait_idle();
    while (poll_queue.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    item_t nx;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (recv_hold != 0) send_gap = 0;
      if (send_gap != 0 || poll_queue.size() == 0) begin
        s_tvalid <= 1'b0;
        if (send_gap != 0) send_gap--;
      end else begin
        nx = poll_queue.pop_front();
        s_tdata <= {{(IN_TDATA_W - $bits(item_t)){1'b0}}, nx};
        s_tvalid <= 1'b1;
        if (send_calm != 0) begin
          send_gap = 0;
          send_calm--;
        end else begin
          send_roll = $urandom_range(0, 99);
          if (send_roll < 45) send_gap = 0;
          else if (send_roll < 80) send_gap = $urandom_range(1, 2);
          else if (send_roll < 93) send_gap = $urandom_range(3, 6);
          else if (send_roll < 98) send_gap = $urandom_range(10, 40);
          else begin
            send_gap = 0;
            send_calm = $urandom_range(20, 60);
          end
        end
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (recv_hold == 0 && results_seen >= next_hold_at && poll_queue.size() > 16) begin
        recv_hold = 60;
        next_hold_at += 300;
      end else if (recv_hold == 0 && recv_calm == 0) begin
        recv_roll = $urandom_range(0, 99);
        if (recv_roll == 0) recv_hold = $urandom_range(8, 30);
        else if (recv_roll < 4) recv_calm = $urandom_range(20, 60);
      end
      if (recv_hold != 0) begin
        m_tready <= 1'b0;
        recv_hold--;
      end else if (recv_calm != 0) begin
        m_tready <= 1'b1;
        recv_calm--;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        expected_reports.push_back(report_for_poll(item_t'(s_tdata[$bits(item_t)-1:0])));
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (expected_reports.size() == 0) begin
          $error("result with no request outstanding: %h", got);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_valid", 32'(want.report_valid), 32'(got.report_valid));
          check_field("wake_request", 32'(want.wake_request), 32'(got.wake_request));
          check_field("button_field", 32'(want.button_field), 32'(got.button_field));
          check_field("hat_code", 32'(want.hat_code), 32'(got.hat_code));
          check_field("left_trigger", 32'(want.left_trigger), 32'(got.left_trigger));
          check_field("right_trigger", 32'(want.right_trigger), 32'(got.right_trigger));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    debounce_cfg = DEBOUNCE_RESET;
    cur_raw = '0;
    cur_stable = '0;
    stable_cnt = '1;
    send_due = 1'b1;
    sent_report = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: pending send with an all-zero report, then a held word
    queue_poll('0, 1'b0, 1'b0, 1'b0);
    queue_poll('0, 1'b1, 1'b0, 1'b0);
    queue_poll('0, 1'b1, 1'b0, 1'b1);
    repeat (22) queue_poll(17'h00020, 1'b1, 1'b0, 1'b0);
    wait_idle();

    // zero debounce, upper data bits ignored
    write_reg(ADDR_DEBOUNCE, 32'hA5C3_7F00);
    queue_poll(17'h00001, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00002, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00003, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00004, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00008, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h0000C, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00009, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h0000A, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00006, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00005, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h0000F, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00000, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h1FFFF, 1'b0, 1'b1, 1'b0);
    queue_poll(17'h1FFFF, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h0FFF0, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h10000, 1'b1, 1'b1, 1'b0);
    queue_poll(17'h00000, 1'b1, 1'b1, 1'b0);
    queue_poll(17'h00400, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00800, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h00800, 1'b1, 1'b0, 1'b1);
    queue_poll(17'h0C000, 1'b0, 1'b0, 1'b1);
    queue_poll(17'h0C000, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h0A0F0, 1'b1, 1'b0, 1'b0);
    queue_poll(17'h1FFFF, 1'b1, 1'b1, 1'b1);
    queue_poll(17'h00000, 1'b1, 1'b0, 1'b0);
    wait_idle();

    // write to a missing register must leave the debounce alone
    write_reg(ADDR_UNUSED, 32'h0000_0007);
    poll_sequences(8);
    wait_idle();

    write_reg(ADDR_DEBOUNCE, 32'h0000_00FF);
    repeat (3) queue_poll_rand(rand_word());
    repeat (2 ** TICK_COUNT_WIDTH + 1) queue_poll_rand(17'h00C05);
    wait_idle();

    write_reg(ADDR_DEBOUNCE, 32'hFFFF_FF01);
    poll_sequences(15);
    wait_idle();

    write_reg(ADDR_DEBOUNCE, $urandom_range(2, 12));
    poll_sequences(8);
    wait_idle();

    write_reg(ADDR_DEBOUNCE, 32'(DEBOUNCE_RESET));
    poll_sequences(3);
    wait_idle();

    repeat (6) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/gdsr_pkg.sv
hdl/gdsr_debounce.sv
hdl/gdsr_report.sv
hdl/gdsr_out_queue.sv
hdl/gamepad_debounce_socd_report_top.sv
tb/sv/tb.sv
